// ===== rtl/core/dtte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dtte_pkg;

  // Decimal fields of one date-time text, as built from its digits.
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } dtte_fields_t;

  // One finished text as it travels from the parser to the arithmetic.
  typedef struct packed {
    dtte_fields_t f;
    logic         ok;
  } dtte_rec_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } dtte_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/dtte_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtte_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [7:0]          text_char,
  input  wire logic                first_char,
  output logic                     push,
  output dtte_pkg::dtte_rec_t      push_rec
);
  import dtte_pkg::*;

  localparam logic [4:0] POS_YEAR_END  = 5'd3;
  localparam logic [4:0] POS_SLASH_A   = 5'd4;
  localparam logic [4:0] POS_MONTH_END = 5'd6;
  localparam logic [4:0] POS_SLASH_B   = 5'd7;
  localparam logic [4:0] POS_DAY_END   = 5'd9;
  localparam logic [4:0] POS_SPACE     = 5'd10;
  localparam logic [4:0] POS_HOUR_END  = 5'd12;
  localparam logic [4:0] POS_COLON_A   = 5'd13;
  localparam logic [4:0] POS_MIN_END   = 5'd15;
  localparam logic [4:0] POS_COLON_B   = 5'd16;
  localparam logic [4:0] POS_LAST      = 5'd18;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [6:0] MONTH_MAX = 7'd12;

  function automatic logic [6:0] push7(input logic [6:0] v, input logic [3:0] d);
    logic [10:0] t;
    t = {4'd0, v} * 11'd10 + {7'd0, d};
    return t[6:0];
  endfunction

  function automatic logic [13:0] push14(input logic [13:0] v, input logic [3:0] d);
    logic [17:0] t;
    t = {4'd0, v} * 18'd10 + {14'd0, d};
    return t[13:0];
  endfunction

  logic [4:0]   pos;
  logic         err;
  dtte_fields_t fld;

  logic [4:0]   pos_eff;
  logic         err_base;
  dtte_fields_t fld_base;
  logic         is_digit;
  logic [3:0]   digit;
  logic         bad;
  logic         err_next;
  dtte_fields_t fld_next;
  logic         at_last;

  always_comb begin
    pos_eff  = first_char ? '0 : pos;
    err_base = first_char ? 1'b0 : err;
    fld_base = first_char ? '0 : fld;
    is_digit = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
    digit    = is_digit ? text_char[3:0] : 4'd0;
    bad      = 1'b0;
    fld_next = fld_base;
    unique case (pos_eff) inside
      POS_SLASH_A, POS_SLASH_B: bad = (text_char != CHAR_SLASH);
      POS_SPACE:                bad = (text_char != CHAR_SPACE);
      POS_COLON_A, POS_COLON_B: bad = (text_char != CHAR_COLON);
      default: begin
        bad = !is_digit;
        if (pos_eff <= POS_YEAR_END) begin
          fld_next.year = push14(fld_base.year, digit);
        end else if (pos_eff <= POS_MONTH_END) begin
          fld_next.month = push7(fld_base.month, digit);
        end else if (pos_eff <= POS_DAY_END) begin
          fld_next.day = push7(fld_base.day, digit);
        end else if (pos_eff <= POS_HOUR_END) begin
          fld_next.hour = push7(fld_base.hour, digit);
        end else if (pos_eff <= POS_MIN_END) begin
          fld_next.minute = push7(fld_base.minute, digit);
        end else begin
          fld_next.second = push7(fld_base.second, digit);
        end
      end
    endcase
    err_next = err_base | bad;
    at_last  = (pos_eff == POS_LAST);
  end

  assign push        = accept && at_last;
  assign push_rec.f  = fld_next;
  assign push_rec.ok = !err_next && (fld_next.month != 7'd0) && (fld_next.month <= MONTH_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      err <= 1'b0;
      fld <= '0;
    end else if (accept) begin
      if (at_last) begin
        pos <= '0;
        err <= 1'b0;
        fld <= '0;
      end else begin
        pos <= pos_eff + 5'd1;
        err <= err_next;
        fld <= fld_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dtte_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtte_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire dtte_pkg::dtte_rec_t push_rec,
  input  wire logic                pop,
  output dtte_pkg::dtte_rec_t      head_rec,
  output logic                     head_valid,
  output dtte_pkg::dtte_qstat_t    stat
);
  import dtte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dtte_rec_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign do_push    = push && (count != CNT_FULL);
  assign do_pop     = pop && (count != '0);
  assign head_rec   = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign stat.full  = (count == CNT_FULL);
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dtte_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtte_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire dtte_pkg::dtte_rec_t in_rec,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              out_seconds,
  output logic                     out_ok
);
  import dtte_pkg::*;

  // Reciprocal of 100 scaled by 2^19; exact for every 14-bit dividend.
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int          RECIP_SH   = 19;
  // 1970 * 365 + leap days before 1970 (478) + 1 for the one-based day.
  localparam logic [31:0] DAYS_BIAS  = 32'd719529;
  localparam logic [31:0] SECS_DAY   = 32'd86400;
  localparam logic [6:0]  MONTH_MARCH = 7'd3;

  function automatic logic [8:0] month_start(input logic [6:0] m);
    logic [8:0] r;
    unique case (m[3:0])
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    dtte_rec_t  r;
    logic [7:0] q100;
  } st_a_t;

  typedef struct packed {
    dtte_rec_t   r;
    logic [12:0] leaps;
    logic        leap;
  } st_b_t;

  typedef struct packed {
    logic        ok;
    logic [22:0] year_days;
    logic [13:0] extra_days;
    logic [18:0] hms;
  } st_c_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] days;
    logic [18:0] hms;
  } st_d_t;

  logic  va, vb, vc, vd;
  st_a_t sa;
  st_b_t sb;
  st_c_t sc;
  st_d_t sd;
  logic  en_a, en_b, en_c, en_d, en_e;

  st_a_t sa_next;
  st_b_t sb_next;
  st_c_t sc_next;
  st_d_t sd_next;
  logic [26:0] q_prod;
  logic [14:0] r_prod;
  logic        r_nz;
  logic [7:0]  q100a;
  logic [14:0] y_p3;
  logic [12:0] q4;
  logic [8:0]  q100a_p3;
  logic [31:0] secs_full;

  assign en_e     = !out_valid || out_ready;
  assign en_d     = !vd || en_e;
  assign en_c     = !vc || en_d;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  always_comb begin
    // Stage A: quotient by 100 through the scaled reciprocal.
    q_prod       = 27'(in_rec.f.year) * 27'(RECIP_100);
    sa_next.r    = in_rec;
    sa_next.q100 = q_prod[RECIP_SH +: 8];

    // Stage B: leap-year count below the year and the leap flag.
    r_prod   = 15'(sa.q100) * 15'd100;
    r_nz     = (sa.r.f.year != r_prod[13:0]);
    q100a    = sa.q100 + {7'd0, r_nz};
    y_p3     = {1'b0, sa.r.f.year} + 15'd3;
    q4       = y_p3[14:2];
    q100a_p3 = {1'b0, q100a} + 9'd3;
    sb_next.r     = sa.r;
    sb_next.leaps = q4 - {5'd0, q100a} + {6'd0, q100a_p3[8:2]};
    sb_next.leap  = ((sa.r.f.year[1:0] == 2'd0) && r_nz) || (!r_nz && (sa.q100[1:0] == 2'd0));

    // Stage C: whole-year days and the small day and time terms.
    sc_next.ok         = sb.r.ok;
    sc_next.year_days  = 23'(sb.r.f.year) * 23'd365;
    sc_next.extra_days = {1'b0, sb.leaps} + {5'd0, month_start(sb.r.f.month)}
                       + {13'd0, (sb.leap && (sb.r.f.month >= MONTH_MARCH))}
                       + {7'd0, sb.r.f.day};
    sc_next.hms        = 19'(sb.r.f.hour) * 19'd3600 + 19'(sb.r.f.minute) * 19'd60
                       + 19'(sb.r.f.second);

    // Stage D: days since the epoch, wrapping modulo 2^32.
    sd_next.ok   = sc.ok;
    sd_next.days = 32'(sc.year_days) + 32'(sc.extra_days) - DAYS_BIAS;
    sd_next.hms  = sc.hms;

    // Stage E: seconds.
    secs_full = sd.days * SECS_DAY + 32'(sd.hms);
  end

  always_ff @(posedge clk) begin
    if (en_a) sa <= sa_next;
    if (en_b) sb <= sb_next;
    if (en_c) sc <= sc_next;
    if (en_d) sd <= sd_next;
    if (en_e) begin
      out_seconds <= sd.ok ? secs_full : 32'd0;
      out_ok      <= sd.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
      if (en_d) vd <= vc;
      if (en_e) out_valid <= vd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/datetime_text_to_epoch_seconds.sv =====
// A result passes through the queue and the registered stages A to E once the last
// character of a text is transferred. Input takes one character per cycle, one result
// per complete 19-character text, and stalls only when the result queue is full.
// Reset (rst, synchronous, active high) clears the character position, the partial
// fields and the error flag, empties the queue and drops every result in flight.
`timescale 1ns / 1ps
`default_nettype none

module datetime_text_to_epoch_seconds #(
  parameter int FIFO_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_char
  input  wire logic        s_tuser,   // [0] first_char
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] epoch_seconds
  output logic             m_tuser    // [0] format_ok
);
  import dtte_pkg::*;

  // The parser takes one character per transfer. It tracks the position in the
  // 19-character text, folds digits into the year, month, day and time fields,
  // and checks separators and digits. On the last character it pushes a
  // finished record into a short queue. The arithmetic pipeline behind the
  // queue turns that record into seconds over five registered stages, the last
  // of which is the output register, so a stalled result never stops the parser
  // until the queue itself fills.

  logic        accept;
  logic        push;
  dtte_rec_t   push_rec;
  dtte_rec_t   head_rec;
  logic        head_valid;
  logic        pop;
  logic        back_ready;
  dtte_qstat_t qstat;

  assign s_tready = !qstat.full;
  assign accept   = s_tvalid && s_tready;
  assign pop      = head_valid && back_ready;

  dtte_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_char  (s_tdata),
    .first_char (s_tuser),
    .push       (push),
    .push_rec   (push_rec)
  );

  dtte_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .head_rec   (head_rec),
    .head_valid (head_valid),
    .stat       (qstat)
  );

  dtte_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (head_valid),
    .in_rec      (head_rec),
    .in_ready    (back_ready),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_seconds (m_tdata),
    .out_ok      (m_tuser)
  );

`ifndef ASSERT_OFF
  // A text that failed the format check must come out as zero seconds.
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
    else $error("flagged result carries nonzero seconds");

  // The parser must never finish a text while the queue has no room.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("record pushed into a full queue");

  // The queue cannot be both full and empty.
  a_qstat_sane: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");
`endif

endmodule

`default_nettype wire

// ===== tb/datetime_text_to_epoch_seconds_test.sv =====
`timescale 1ns / 1ps

module datetime_text_to_epoch_seconds_test;

  // Layout of the "yyyy/mm/dd HH:MM:SS" text.
  localparam int TEXT_LEN       = 19;
  localparam int POS_DATE_SEP_A = 4;
  localparam int POS_DATE_SEP_B = 7;
  localparam int POS_SPACE      = 10;
  localparam int POS_TIME_SEP_A = 13;
  localparam int POS_TIME_SEP_B = 16;
  localparam int LAST_YEAR_POS  = 3;
  localparam int LAST_MONTH_POS = 6;
  localparam int LAST_DAY_POS   = 9;
  localparam int LAST_HOUR_POS  = 12;
  localparam int LAST_MIN_POS   = 15;

  localparam byte unsigned ZERO_CH  = "0";
  localparam byte unsigned NINE_CH  = "9";
  localparam byte unsigned SLASH_CH = "/";
  localparam byte unsigned SPACE_CH = " ";
  localparam byte unsigned COLON_CH = ":";

  localparam int unsigned EPOCH_YEAR   = 1970;
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned MONTH_START [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  // Stimulus shape: total characters, when the long output hold-off starts,
  // how long it lasts, and when the random idling stops.
  localparam int CHAR_TARGET  = 1250;
  localparam int MIN_STAMPS   = 48;
  localparam int HOLD_AT      = 400;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_AT     = 1050;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  // One expected output transfer.
  typedef struct packed {
    bit [31:0] secs;
    bit        ok;
  } stamp_t;

  // Tracks the text parser state and holds the timestamps still owed by the block.
  class epoch_scoreboard;
    bit [4:0]  pos;
    bit [13:0] yr;
    bit [6:0]  mon, dom, hr, mn, sc;
    bit        bad;
    stamp_t    stamp_q[$];
    int        errors;
    int        stamps_due;

    function void clear_text();
      pos = '0;
      yr  = '0;
      mon = '0;
      dom = '0;
      hr  = '0;
      mn  = '0;
      sc  = '0;
      bad = 1'b0;
    endfunction

    function bit is_leap(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // Leap years in [0, y).
    function int unsigned leaps_below(int unsigned y);
      return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    // Seconds since 1970 for the fields collected so far, wrapping at 32 bits.
    function bit [31:0] text_seconds();
      int unsigned y;
      int unsigned days;
      y = yr;
      days = (y - EPOCH_YEAR) * 365 + leaps_below(y) - leaps_below(EPOCH_YEAR);
      days = days + MONTH_START[int'(mon) - 1];
      if (mon >= 3 && is_leap(y)) days = days + 1;
      days = days + dom - 32'd1;
      return days * SECS_PER_DAY + hr * 32'd3600 + mn * 32'd60 + sc;
    endfunction

    function void note_char(byte unsigned c, bit restart);
      bit [4:0]    p;
      bit          is_digit;
      int unsigned d;
      stamp_t      stamp;
      if (restart) clear_text();
      if (pos >= TEXT_LEN) clear_text();
      p = pos;
      is_digit = (c >= ZERO_CH) && (c <= NINE_CH);
      d = is_digit ? c - ZERO_CH : 0;
      case (p)
        POS_DATE_SEP_A, POS_DATE_SEP_B: if (c != SLASH_CH) bad = 1'b1;
        POS_SPACE:                      if (c != SPACE_CH) bad = 1'b1;
        POS_TIME_SEP_A, POS_TIME_SEP_B: if (c != COLON_CH) bad = 1'b1;
        default: begin
          if (!is_digit) bad = 1'b1;
          // A non-digit still shifts the field, as a zero digit.
          if (p <= LAST_YEAR_POS) yr = 14'(yr * 10 + d);
          else if (p <= LAST_MONTH_POS) mon = 7'(mon * 10 + d);
          else if (p <= LAST_DAY_POS) dom = 7'(dom * 10 + d);
          else if (p <= LAST_HOUR_POS) hr = 7'(hr * 10 + d);
          else if (p <= LAST_MIN_POS) mn = 7'(mn * 10 + d);
          else sc = 7'(sc * 10 + d);
        end
      endcase
      if (p + 1 < TEXT_LEN) begin
        pos = p + 5'd1;
      end else begin
        if (bad || mon < 1 || mon > 12) begin
          stamp.secs = '0;
          stamp.ok   = 1'b0;
        end else begin
          stamp.secs = text_seconds();
          stamp.ok   = 1'b1;
        end
        stamp_q.push_back(stamp);
        stamps_due++;
        clear_text();
      end
    endfunction

    function void check_stamp(bit [31:0] secs, bit ok);
      stamp_t want;
      if (stamp_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result secs=%0d ok=%0b", $realtime, secs, ok);
        return;
      end
      want = stamp_q.pop_front();
      if (want.secs !== secs || want.ok !== ok) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch, expected secs=%0d ok=%0b, got secs=%0d ok=%0b",
                   $realtime, want.secs, want.ok, secs, ok);
      end
    endfunction

    function int pending();
      return stamp_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] text_char
  logic        s_tuser = 1'b0; // [0] first_char
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] epoch_seconds
  logic        m_tuser;        // [0] format_ok

  epoch_scoreboard sb = new();

  // Idling is switched off for the last part of the run.
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  bit long_hold_req = 1'b0;
  int chars_sent = 0;

  datetime_text_to_epoch_seconds dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one character and waits for its transfer. The valid is only
  // dropped when a gap is inserted, so it never toggles within one step.
  task automatic send_char(input byte unsigned c, input bit restart, input bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= restart;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_char(c, restart);
    chars_sent++;
    if (chars_sent == HOLD_AT) long_hold_req = 1'b1;
    if (chars_sent == QUIET_AT) begin
      idle_on  = 1'b0;
      stall_on = 1'b0;
    end
  endtask

  task automatic send_text(input byte unsigned txt [TEXT_LEN], input int count,
                           input bit restart, input bit gaps);
    for (int i = 0; i < count; i++) send_char(txt[i], (i == 0) ? restart : 1'b0, gaps);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0, 1'b0);
  endtask

  function automatic void put_num(ref byte unsigned txt [TEXT_LEN], input int at,
                                  input int ndig, input int unsigned val);
    for (int i = ndig - 1; i >= 0; i--) begin
      txt[at + i] = 8'(ZERO_CH + val % 10);
      val = val / 10;
    end
  endfunction

  function automatic void make_text(ref byte unsigned txt [TEXT_LEN],
                                    input int unsigned yy, mo, dd, hh, mi, ss);
    put_num(txt, 0, 4, yy);
    txt[POS_DATE_SEP_A] = SLASH_CH;
    put_num(txt, POS_DATE_SEP_A + 1, 2, mo);
    txt[POS_DATE_SEP_B] = SLASH_CH;
    put_num(txt, POS_DATE_SEP_B + 1, 2, dd);
    txt[POS_SPACE] = SPACE_CH;
    put_num(txt, POS_SPACE + 1, 2, hh);
    txt[POS_TIME_SEP_A] = COLON_CH;
    put_num(txt, POS_TIME_SEP_A + 1, 2, mi);
    txt[POS_TIME_SEP_B] = COLON_CH;
    put_num(txt, POS_TIME_SEP_B + 1, 2, ss);
  endfunction

  function automatic bit is_sep_pos(int p);
    return p == POS_DATE_SEP_A || p == POS_DATE_SEP_B || p == POS_SPACE ||
           p == POS_TIME_SEP_A || p == POS_TIME_SEP_B;
  endfunction

  // Years around the epoch, the wrap of the 32-bit count and the century leap rules.
  function automatic int unsigned pick_year();
    int unsigned notable [12] =
      '{1970, 1969, 0, 9999, 2000, 1900, 2100, 2400, 2024, 2038, 2106, 1972};
    if ($urandom_range(0, 2) == 0) return notable[$urandom_range(0, 11)];
    return $urandom_range(0, 9999);
  endfunction

  // Pick a field value: usually within its calendar range, sometimes anything
  // two digits can hold.
  function automatic int unsigned pick_field(int unsigned lo, int unsigned hi);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 99);
    return $urandom_range(lo, hi);
  endfunction

  // Output side: short random stalls, plus one long hold-off that lets the
  // result queue fill so that the input side backs up.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end else if (hold == 0 && stall_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 5);
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Every output transfer is checked against the oldest expected timestamp.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) sb.check_stamp(m_tdata, m_tuser);
  end

  initial begin
    byte unsigned txt [TEXT_LEN];
    int unsigned  kind, yy, mo, dd, hh, mi, ss;
    int           p;
    byte unsigned c;
    bit           gaps;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the last second that fits in 32 bits, then a text that is
    // cut short; the texts after it carry on from there until one restarts.
    send_string("2106/02/07 06:28:15");
    send_string("0000/1");

    while (chars_sent < CHAR_TARGET || sb.stamps_due < MIN_STAMPS) begin
      kind = $urandom_range(0, 99);
      yy = pick_year();
      mo = $urandom_range(1, 12);
      dd = pick_field(1, 31);
      hh = pick_field(0, 23);
      mi = pick_field(0, 59);
      ss = pick_field(0, 59);
      // Month outside 1..12.
      if (kind >= 80 && kind < 88) begin
        case ($urandom_range(0, 3))
          0: mo = 0;
          1: mo = 13;
          2: mo = 99;
          default: mo = $urandom_range(13, 99);
        endcase
      end
      make_text(txt, yy, mo, dd, hh, mi, ss);
      // Wrong separator at one of the five separator positions.
      if (kind >= 60 && kind < 70) begin
        case ($urandom_range(0, 4))
          0: p = POS_DATE_SEP_A;
          1: p = POS_DATE_SEP_B;
          2: p = POS_SPACE;
          3: p = POS_TIME_SEP_A;
          default: p = POS_TIME_SEP_B;
        endcase
        do c = 8'($urandom_range(0, 255)); while (c == txt[p]);
        txt[p] = c;
      end
      // A non-digit where a digit belongs.
      if (kind >= 70 && kind < 80) begin
        do p = $urandom_range(0, TEXT_LEN - 1); while (is_sep_pos(p));
        do c = 8'($urandom_range(0, 255)); while (c >= ZERO_CH && c <= NINE_CH);
        txt[p] = c;
      end
      gaps = idle_on && $urandom_range(0, 3) != 0;
      if (kind >= 94) begin
        // Raw noise, with the occasional restart flag.
        repeat ($urandom_range(1, 25))
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, gaps);
      end else if (kind >= 88) begin
        // Restart in the middle of a text, then the full text again.
        send_text(txt, $urandom_range(1, TEXT_LEN - 1), 1'b1, gaps);
        send_text(txt, TEXT_LEN, 1'b1, gaps);
      end else begin
        send_text(txt, TEXT_LEN, $urandom_range(0, 3) != 0, gaps);
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS datetime_text_to_epoch_seconds");
    end else begin
      $display("FAIL datetime_text_to_epoch_seconds");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL datetime_text_to_epoch_seconds");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dtte_pkg.sv
rtl/core/dtte_front.sv
rtl/core/dtte_fifo.sv
rtl/core/dtte_back.sv
rtl/core/datetime_text_to_epoch_seconds.sv
tb/datetime_text_to_epoch_seconds_test.sv
